/* hw/rtl/nst_pkg.sv */
// shared constants, types and the name normalizer for the named session table
`default_nettype none

package nst_pkg;

  localparam int SLOTS      = 32;
  localparam int NAME_BYTES = 32;
  localparam int KEY_WORDS  = 4;
  localparam int KEY_W      = 64 * KEY_WORDS;
  localparam int HANDLE_W   = 16;
  localparam int CAP_W      = 6;
  localparam int KIND_W     = 2;
  localparam int COUNT_W    = $clog2(SLOTS + 1);
  localparam int N_W        = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  localparam logic [KIND_W-1:0] KIND_CONNECT     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROP_NAME   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROP_HANDLE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LOOKUP      = 2'd3;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [KIND_W-1:0]   kind_t;

  // request broadcast to every cell
  typedef struct packed {
    kind_t   kind;
    key_t    key;
    handle_t handle;
  } nst_req_t;

  // update strobe broadcast to every cell
  typedef struct packed {
    logic commit;
    logic fill_ok;
  } nst_cmd_t;

  // what one cell hands to the next one up the row
  typedef struct packed {
    logic    hit_seen;
    logic    free_seen;
    handle_t hout;
  } nst_chain_t;

  // zero every byte from the first zero byte on, and every byte past NAME_BYTES
  function automatic key_t nst_normalize(input key_t raw);
    key_t k;
    logic ended;
    k     = '0;
    ended = 1'b0;
    for (int p = 0; p < KEY_W / 8; p++) begin
      if (p >= NAME_BYTES || raw[p*8 +: 8] == 8'd0) ended = 1'b1;
      if (!ended) k[p*8 +: 8] = raw[p*8 +: 8];
    end
    return k;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/nst_ifs.sv */
// valid/ready channel interfaces for requests, results and configuration
`default_nettype none

interface nst_req_if import nst_pkg::*; ();
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [63:0] name_word0;
  logic [63:0] name_word1;
  logic [63:0] name_word2;
  logic [63:0] name_word3;
  handle_t     handle;

  modport source (output valid, kind, name_word0, name_word1, name_word2, name_word3, handle,
                  input ready);
  modport sink   (input valid, kind, name_word0, name_word1, name_word2, name_word3, handle,
                  output ready);
endinterface

interface nst_rsp_if import nst_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    fail;
  logic    found;
  handle_t handle_out;

  modport source (output valid, fail, found, handle_out, input ready);
  modport sink   (input valid, fail, found, handle_out, output ready);
endinterface

interface nst_cfg_if import nst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

`default_nettype wire

/* hw/rtl/nst_cell.sv */
// one table slot: holds valid, key and handle, matches and passes priority up the row
`default_nettype none

module nst_cell import nst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  nst_req_t   req,
  input  nst_cmd_t   cmd,
  input  logic       in_use,
  input  nst_chain_t chain_in,
  output nst_chain_t chain_out,
  output logic       valid_o
);

  logic    valid_r, valid_nxt;
  key_t    key_r, key_nxt;
  handle_t handle_r, handle_nxt;
  logic    hit_r, hit_nxt;
  logic    free_r, free_nxt;
  logic    first_hit, first_free;

  assign hit_nxt = valid_r && in_use &&
                   ((req.kind == KIND_DROP_HANDLE) ? (handle_r == req.handle)
                                                   : (key_r == req.key));
  assign free_nxt = !valid_r && in_use;

  // lowest slot wins: only the first flagged cell along the row acts
  assign first_hit  = hit_r && !chain_in.hit_seen;
  assign first_free = free_r && !chain_in.free_seen;

  assign chain_out.hit_seen  = chain_in.hit_seen | hit_r;
  assign chain_out.free_seen = chain_in.free_seen | free_r;
  assign chain_out.hout      = chain_in.hout | (first_hit ? handle_r : '0);

  assign valid_o = valid_r;

  always_comb begin
    valid_nxt  = valid_r;
    key_nxt    = key_r;
    handle_nxt = handle_r;
    if (cmd.commit) begin
      case (req.kind)
        KIND_CONNECT: begin
          if (first_hit) begin
            handle_nxt = req.handle;
          end else if (cmd.fill_ok && first_free) begin
            valid_nxt  = 1'b1;
            key_nxt    = req.key;
            handle_nxt = req.handle;
          end
        end
        KIND_DROP_NAME, KIND_DROP_HANDLE: begin
          if (first_hit) valid_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
      free_r  <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    handle_r <= handle_nxt;
  end

endmodule

`default_nettype wire

/* hw/rtl/named_session_table.sv */
// top level of the named session table: request control, slot row and result register
//
//   channel  dir  handshake            word
//   in_ch    in   valid/ready          kind, name_word0..3, handle
//   out_ch   out  valid/ready          fail, found, handle_out
//   cfg_ch   in   valid/ready (ready=1) capacity
//
// a request is handled in order: capture and normalize, match in every slot, then pick
// the lowest matching or free slot along the cell row and commit.
// the commit waits while the result register holds a word not yet taken.
// a new request is taken once the previous one has committed.
// reset clears all slot valid marks and the count at once; no clearing pass.
`default_nettype none

module named_session_table import nst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  nst_req_if.sink          in_ch,
  nst_rsp_if.source        out_ch,
  nst_cfg_if.sink          cfg_ch
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_PICK  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  nst_req_t           req_r;
  logic [CAP_W-1:0]   capacity_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r;
  logic               fail_r, found_r;
  handle_t            handle_out_r;

  logic               accept;
  logic               commit;
  logic [N_W-1:0]     slots_used;
  logic               can_fill;
  logic               any_hit, any_free;
  logic               filled, dropped;
  logic               fail_nxt;
  logic [SLOTS-1:0]   in_use;
  logic [SLOTS-1:0]   slot_valid;
  nst_cmd_t           cmd;
  nst_chain_t         chain [SLOTS+1];

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign commit = (state_r == ST_PICK) && (!out_valid_r || out_ch.ready);

  assign cfg_ch.ready = 1'b1;

  assign slots_used = (N_W'(capacity_r) < N_W'(SLOTS)) ? N_W'(capacity_r) : N_W'(SLOTS);
  assign can_fill   = N_W'(count_r) < slots_used;

  assign chain[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      assign in_use[gi] = N_W'(gi) < slots_used;
      nst_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_r),
        .cmd       (cmd),
        .in_use    (in_use[gi]),
        .chain_in  (chain[gi]),
        .chain_out (chain[gi+1]),
        .valid_o   (slot_valid[gi])
      );
    end
  endgenerate

  assign any_hit  = chain[SLOTS].hit_seen;
  assign any_free = chain[SLOTS].free_seen;

  assign cmd.commit  = commit;
  assign cmd.fill_ok = !any_hit && can_fill;

  assign filled   = (req_r.kind == KIND_CONNECT) && !any_hit && can_fill && any_free;
  assign dropped  = ((req_r.kind == KIND_DROP_NAME) || (req_r.kind == KIND_DROP_HANDLE))
                    && any_hit;
  assign fail_nxt = (req_r.kind == KIND_CONNECT) && !any_hit && !(can_fill && any_free);

  always_comb begin
    count_nxt = count_r;
    if (commit && filled) begin
      count_nxt = count_r + COUNT_W'(1);
    end else if (commit && dropped && count_r != '0) begin
      count_nxt = count_r - COUNT_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_PICK;
      ST_PICK:  if (commit) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      capacity_r  <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_ch.valid) capacity_r <= cfg_ch.capacity;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.kind   <= in_ch.kind;
      req_r.key    <= nst_normalize({in_ch.name_word3, in_ch.name_word2,
                                     in_ch.name_word1, in_ch.name_word0});
      req_r.handle <= in_ch.handle;
    end
    if (commit) begin
      fail_r       <= fail_nxt;
      found_r      <= any_hit;
      handle_out_r <= (req_r.kind == KIND_LOOKUP) ? chain[SLOTS].hout : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.fail       = fail_r;
  assign out_ch.found      = found_r;
  assign out_ch.handle_out = handle_out_r;

  // count tracks the number of valid slots exactly
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == COUNT_W'($countones(slot_valid)))
    else $error("occupied count differs from valid slots");

  a_fail_found_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(fail_r && found_r))
    else $error("fail and found both set");

  a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (state_r == ST_IDLE))
    else $error("no return to idle after commit");

  a_slots_stable_without_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(slot_valid))
    else $error("slot valid marks changed without a commit");

endmodule

`default_nettype wire
